FILE: src/etc_pkg.sv
package etc_pkg;

    // Width of the position and length counters; both saturate at all ones.
    localparam int POSITION_BITS = 16;

    // Depth of the result queue in front of the output port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_FUNCS = 6;
    localparam int NAME_SLOTS = 8;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [NUM_FUNCS-1:0] fn_mask_t;
    typedef logic [QUEUE_CNT_BITS-1:0] queue_cnt_t;

    typedef enum logic [2:0] {
        TOK_SPACE    = 3'd0,
        TOK_NUMBER   = 3'd1,
        TOK_OPERATOR = 3'd2,
        TOK_LPAREN   = 3'd3,
        TOK_RPAREN   = 3'd4,
        TOK_FUNCTION = 3'd5,
        TOK_VARIABLE = 3'd6,
        TOK_UNKNOWN  = 3'd7
    } tok_class_t;

    // Function identifiers.
    localparam logic [2:0] FN_SIN   = 3'd0;
    localparam logic [2:0] FN_COS   = 3'd1;
    localparam logic [2:0] FN_TAN   = 3'd2;
    localparam logic [2:0] FN_COT   = 3'd3;
    localparam logic [2:0] FN_MINUS = 3'd4;
    localparam logic [2:0] FN_ABS   = 3'd5;

    // Special bytes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] DECIMAL_POINT_RESET = 8'h2E;

    // Function names, padded with zero bytes so any 3-bit index is in range.
    localparam logic [7:0] FN_NAME [NUM_FUNCS][NAME_SLOTS] = '{
        '{"s", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "i", "n", "u",   "s",   8'h00, 8'h00, 8'h00},
        '{"a", "b", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] FN_LEN [NUM_FUNCS] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd3};

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        tok_class_t  token_class;
        logic [15:0] start_position;
        logic [15:0] token_length;
        logic [7:0]  first_character;
        logic [2:0]  function_id;
        logic        last_of_run;
    } out_t;

    // State of the word now being built.
    typedef struct packed {
        pos_t       start;
        pos_t       length;
        logic [7:0] first_char;
        logic       numeric;
        logic       letters;
        fn_mask_t   mask;
    } word_t;

    localparam word_t WORD_CLEAR = '{
        start: '0, length: '0, first_char: 8'h00,
        numeric: 1'b1, letters: 1'b1, mask: '1
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    endfunction

    function automatic logic is_split(input logic [7:0] c);
        return is_op(c) || (c inside {CH_SPACE, CH_NEWLINE, CH_LPAREN, CH_RPAREN});
    endfunction

    function automatic pos_t sat_inc(input pos_t v);
        return (v == '1) ? v : v + pos_t'(1);
    endfunction

    // Token for a finished word.
    function automatic out_t word_token(input word_t w, input logic last);
        out_t       t;
        logic       found;
        logic [2:0] fid;
        found = 1'b0;
        fid   = FN_SIN;
        // Scan from the top so that the lowest matching name wins.
        for (int i = NUM_FUNCS - 1; i >= 0; i--) begin
            if (w.mask[i] && (w.length == pos_t'(FN_LEN[i]))) begin
                found = 1'b1;
                fid   = 3'(i);
            end
        end
        t.start_position  = 16'(w.start);
        t.token_length    = 16'(w.length);
        t.first_character = w.first_char;
        t.last_of_run     = last;
        t.function_id     = FN_SIN;
        if (w.numeric) begin
            t.token_class = TOK_NUMBER;
        end else if (found) begin
            t.token_class = TOK_FUNCTION;
            t.function_id = fid;
        end else if (w.letters) begin
            t.token_class = TOK_VARIABLE;
        end else begin
            t.token_class = TOK_UNKNOWN;
        end
        return t;
    endfunction

    // Token for a single split byte; the decimal point takes priority after space.
    function automatic out_t split_token(input logic [7:0] c, input pos_t pos,
                                         input logic [7:0] dp);
        out_t t;
        t.start_position  = 16'(pos);
        t.token_length    = 16'd1;
        t.first_character = c;
        t.function_id     = FN_SIN;
        t.last_of_run     = 1'b1;
        if (c == CH_SPACE) begin
            t.token_class = TOK_SPACE;
        end else if (c == dp) begin
            t.token_class = TOK_NUMBER;
        end else if (is_op(c)) begin
            t.token_class = TOK_OPERATOR;
        end else if (c == CH_LPAREN) begin
            t.token_class = TOK_LPAREN;
        end else if (c == CH_RPAREN) begin
            t.token_class = TOK_RPAREN;
        end else begin
            t.token_class = TOK_UNKNOWN;
        end
        return t;
    endfunction

endpackage

FILE: src/etc_out_queue.sv
module etc_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_count,
    input  etc_pkg::out_t         push0,
    input  etc_pkg::out_t         push1,
    output logic                  ready,
    output logic                  valid,
    input  logic                  stall,
    output etc_pkg::out_t         data
);
    import etc_pkg::*;

    out_t       slot_reg [QUEUE_DEPTH];
    out_t       slot_next [QUEUE_DEPTH];
    queue_cnt_t count_reg;
    queue_cnt_t count_next;
    queue_cnt_t fill_base;
    logic       pop;

    // The head slot drives the port; room for two beats is required to take an item.
    assign valid = (count_reg != '0);
    assign data  = slot_reg[0];
    assign pop   = valid && !stall;
    assign ready = (count_reg <= queue_cnt_t'(QUEUE_DEPTH - 2));

    // Shift on a pop, then place new beats just behind the remaining ones.
    always_comb
    begin
        fill_base = count_reg - queue_cnt_t'(pop);
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_next[k] = slot_reg[k];
        end
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                slot_next[k] = slot_reg[k + 1];
            end
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if ((push_count != 2'd0) && (queue_cnt_t'(k) == fill_base)) begin
                slot_next[k] = push0;
            end
            if ((push_count == 2'd2) && (queue_cnt_t'(k) == fill_base + queue_cnt_t'(1))) begin
                slot_next[k] = push1;
            end
        end
        count_next = fill_base + queue_cnt_t'(push_count);
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_reg[k] <= slot_next[k];
        end
    end

endmodule

FILE: src/expression_token_classifier.sv
// Channel | Direction | Handshake           | Beat
// in      | input     | in_valid / in_stall | one text byte and its end-of-text mark
// out     | output    | out_valid/out_stall | one token
// cfg     | input     | cfg_valid/cfg_ready | decimal point byte
//
// One byte is taken per cycle while in_stall is low; the word state updates in the
// same cycle and the zero, one or two tokens it causes enter a four-entry queue,
// which sends one per cycle while out_stall is low. The input stalls while fewer
// than two queue entries are free. Reset clears the word state and position and
// sets the decimal point to '.'. cfg_ready is always high.
module expression_token_classifier (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  etc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output etc_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);
    import etc_pkg::*;

    pos_t       pos_reg;
    pos_t       pos_next;
    word_t      word_reg;
    word_t      word_next;
    logic [7:0] dp_reg;

    word_t      word_base;
    word_t      word_grown;
    logic [7:0] c;
    logic       eot;
    logic       split;
    logic       word_open;
    logic       accept;
    logic       queue_ready;
    logic [1:0] push_count;
    out_t       push0;
    out_t       push1;

    assign c         = in_data.character;
    assign eot       = in_data.end_of_text;
    assign split     = is_split(c);
    assign word_open = (word_reg.length != '0);
    assign accept    = in_valid && queue_ready;
    assign in_stall  = !queue_ready;
    assign cfg_ready = 1'b1;

    // Extend the open word, or start a new one, with the current byte.
    always_comb
    begin
        if (word_open) begin
            word_base = word_reg;
        end else begin
            word_base            = WORD_CLEAR;
            word_base.start      = pos_reg;
            word_base.first_char = c;
        end
        word_grown         = word_base;
        word_grown.numeric = word_base.numeric && (is_digit(c) || (c == dp_reg));
        word_grown.letters = word_base.letters && is_alpha(c);
        for (int i = 0; i < NUM_FUNCS; i++) begin
            if ((word_base.length >= pos_t'(FN_LEN[i])) ||
                (FN_NAME[i][word_base.length[2:0]] != c)) begin
                word_grown.mask[i] = 1'b0;
            end
        end
        word_grown.length = sat_inc(word_base.length);
    end

    // Tokens caused by this byte: the closed word first, then the split byte.
    always_comb
    begin
        push0      = split_token(c, pos_reg, dp_reg);
        push1      = split_token(c, pos_reg, dp_reg);
        push_count = 2'd0;
        if (split) begin
            if (word_open) begin
                push0      = word_token(word_reg, 1'b0);
                push_count = 2'd2;
            end else begin
                push_count = 2'd1;
            end
        end else if (eot) begin
            push0      = word_token(word_grown, 1'b1);
            push_count = 2'd1;
        end
        if (!accept) begin
            push_count = 2'd0;
        end
    end

    // Next word state and position.
    always_comb
    begin
        word_next = (split || eot) ? WORD_CLEAR : word_grown;
        pos_next  = eot ? pos_t'(0) : sat_inc(pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            word_reg <= WORD_CLEAR;
        end else if (accept) begin
            pos_reg  <= pos_next;
            word_reg <= word_next;
        end
    end

    // Decimal point register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dp_reg <= DECIMAL_POINT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dp_reg <= cfg_data;
        end
    end

    etc_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (push0),
        .push1      (push1),
        .ready      (queue_ready),
        .valid      (out_valid),
        .stall      (out_stall),
        .data       (out_data)
    );

endmodule

FILE: tb/sv/etc_checker.sv
`timescale 1ns / 1ps

module etc_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  etc_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  etc_pkg::out_t out_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [7:0]    cfg_data,
    output int            mismatches,
    output int            tokens_pending,
    output int            tokens_checked
);
    import etc_pkg::*;

    // Spelling of the recognized function names, padded with zero bytes.
    localparam logic [7:0] NAME_BYTES [NUM_FUNCS][5] = '{
        '{"s", "i", "n", 8'h00, 8'h00},
        '{"c", "o", "s", 8'h00, 8'h00},
        '{"t", "a", "n", 8'h00, 8'h00},
        '{"c", "o", "t", 8'h00, 8'h00},
        '{"m", "i", "n", "u",   "s"},
        '{"a", "b", "s", 8'h00, 8'h00}
    };
    localparam int NAME_LENGTHS [NUM_FUNCS] = '{3, 3, 3, 3, 5, 3};

    // Local copy of the decimal point register and of the open word.
    logic [7:0] point_char;
    pos_t       text_pos;
    pos_t       word_start;
    pos_t       word_len;
    logic [7:0] word_first;
    logic       word_numeric;
    logic       word_letters;
    fn_mask_t   word_mask;

    // Tokens predicted but not yet seen on the output.
    out_t predicted_tokens [$];

    function automatic logic is_operator_char(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_NEWLINE, CH_LPAREN, CH_RPAREN: return 1'b1;
            default: return is_operator_char(c);
        endcase
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic logic is_letter_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    // Counters stick at all ones.
    function automatic pos_t bump(input pos_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic clear_word();
        word_start   = '0;
        word_len     = '0;
        word_first   = 8'h00;
        word_numeric = 1'b1;
        word_letters = 1'b1;
        word_mask    = '1;
    endtask

    // Token for the open word: number first, then the lowest matching name,
    // then a plain letter word, else unknown.
    function automatic out_t finished_word();
        out_t t;
        int   i;
        t = '0;
        t.start_position  = 16'(word_start);
        t.token_length    = 16'(word_len);
        t.first_character = word_first;
        t.token_class     = TOK_UNKNOWN;
        if (word_numeric)
        begin
            t.token_class = TOK_NUMBER;
        end
        else
        begin
            for (i = 0; i < NUM_FUNCS; i++)
            begin
                if (t.token_class != TOK_FUNCTION && word_mask[i] &&
                    word_len == pos_t'(NAME_LENGTHS[i]))
                begin
                    t.token_class = TOK_FUNCTION;
                    t.function_id = 3'(i);
                end
            end
            if (t.token_class != TOK_FUNCTION && word_letters)
                t.token_class = TOK_VARIABLE;
        end
        return t;
    endfunction

    // Token for a separator byte; the decimal point outranks everything but space.
    function automatic out_t split_byte_token(input logic [7:0] c, input pos_t pos);
        out_t t;
        t = '0;
        t.start_position  = 16'(pos);
        t.token_length    = 16'd1;
        t.first_character = c;
        if (c == CH_SPACE)
            t.token_class = TOK_SPACE;
        else if (c == point_char)
            t.token_class = TOK_NUMBER;
        else if (is_operator_char(c))
            t.token_class = TOK_OPERATOR;
        else if (c == CH_LPAREN)
            t.token_class = TOK_LPAREN;
        else if (c == CH_RPAREN)
            t.token_class = TOK_RPAREN;
        else
            t.token_class = TOK_UNKNOWN;
        return t;
    endfunction

    // Advance the word state by one byte and queue the tokens it produces.
    task automatic tokenize_byte(input logic [7:0] c, input logic eot);
        out_t made [2];
        int   n;
        int   i;
        n = 0;
        if (is_separator(c))
        begin
            if (word_len != 0)
            begin
                made[n] = finished_word();
                n++;
            end
            clear_word();
            made[n] = split_byte_token(c, text_pos);
            n++;
        end
        else
        begin
            if (word_len == 0)
            begin
                clear_word();
                word_start = text_pos;
                word_first = c;
            end
            if (!(is_digit_char(c) || c == point_char))
                word_numeric = 1'b0;
            if (!is_letter_char(c))
                word_letters = 1'b0;
            for (i = 0; i < NUM_FUNCS; i++)
            begin
                if (word_len >= pos_t'(NAME_LENGTHS[i]))
                    word_mask[i] = 1'b0;
                else if (NAME_BYTES[i][word_len[2:0]] != c)
                    word_mask[i] = 1'b0;
            end
            word_len = bump(word_len);
            if (eot)
            begin
                made[n] = finished_word();
                n++;
            end
        end

        // The end of the text restarts the position count.
        if (eot)
        begin
            text_pos = '0;
            clear_word();
        end
        else
        begin
            text_pos = bump(text_pos);
        end

        if (n > 0)
            made[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++)
            predicted_tokens.push_back(made[i]);
    endtask

    task automatic flag_field(input string field, input longint want, input longint got);
        mismatches++;
        $error("%s expected %0d got %0d", field, want, got);
    endtask

    // Predict on input beats, compare on output beats, track register writes.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            point_char = DECIMAL_POINT_RESET;
            text_pos   = '0;
            clear_word();
            predicted_tokens.delete();
            mismatches     = 0;
            tokens_checked = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tokenize_byte(in_data.character, in_data.end_of_text);

            if (out_valid && !out_stall)
            begin
                tokens_checked++;
                if (predicted_tokens.size() == 0)
                begin
                    mismatches++;
                    $error("token with no prediction: class %0d start %0d",
                           out_data.token_class, out_data.start_position);
                end
                else
                begin
                    want = predicted_tokens.pop_front();
                    if (out_data.token_class !== want.token_class)
                        flag_field("token_class", want.token_class, out_data.token_class);
                    if (out_data.start_position !== want.start_position)
                        flag_field("start_position", want.start_position,
                                   out_data.start_position);
                    if (out_data.token_length !== want.token_length)
                        flag_field("token_length", want.token_length, out_data.token_length);
                    if (out_data.first_character !== want.first_character)
                        flag_field("first_character", want.first_character,
                                   out_data.first_character);
                    if (out_data.function_id !== want.function_id)
                        flag_field("function_id", want.function_id, out_data.function_id);
                    if (out_data.last_of_run !== want.last_of_run)
                        flag_field("last_of_run", want.last_of_run, out_data.last_of_run);
                end
            end

            if (cfg_valid && cfg_ready)
                point_char = cfg_data;
        end
        tokens_pending = predicted_tokens.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import etc_pkg::*;

    localparam int     HALF_PERIOD   = 2;
    localparam int     RESET_CYCLES  = 8;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     PHASE_BYTES   = 175;
    localparam int     NUM_SETTINGS  = 8;
    localparam longint TIMEOUT_NS    = 3_000_000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;

    int mismatches;
    int tokens_pending;
    int tokens_checked;

    // Sender pacing and the decimal point that the text builder uses.
    bit         sender_gaps = 1'b0;
    int         burst_left  = 0;
    int         bytes_sent  = 0;
    logic [7:0] text_point  = DECIMAL_POINT_RESET;
    logic [7:0] text_bytes [$];

    // Receiver stall pattern state.
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_hold  = 0;
    bit stall_level = 1'b0;

    string      func_words [NUM_FUNCS] = '{"sin", "cos", "tan", "cot", "minus", "abs"};
    logic [7:0] separators [9] = '{CH_SPACE, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                   CH_CARET, CH_LPAREN, CH_RPAREN, CH_NEWLINE};

    expression_token_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    etc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    always #HALF_PERIOD clk = ~clk;

    // The receiver switches between no stall, random stall, a periodic
    // pattern and long on/off stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= (stall_left % 3 == 0);
            default:
            begin
                if (stall_hold == 0)
                begin
                    stall_level = ~stall_level;
                    stall_hold  = $urandom_range(1, 16);
                end
                stall_hold--;
                out_stall <= stall_level;
            end
        endcase
    end

    // One input beat; valid stays high into the next beat unless a gap opens.
    task automatic send_beat(input logic [7:0] ch, input logic eot);
        if (sender_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{character: ch, end_of_text: eot};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(s[i], i == s.len() - 1);
    endtask

    task automatic send_text_bytes();
        int i;
        for (i = 0; i < text_bytes.size(); i++)
            send_beat(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    // Arbitrary bytes with end-of-text marks scattered at random.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    endtask

    // Build an expression from numbers, names, variables, operators and parens.
    task automatic build_expression();
        int    pieces;
        int    k;
        int    n;
        int    i;
        int    point_at;
        string fname;
        text_bytes.delete();
        pieces = $urandom_range(1, 7);
        for (k = 0; k < pieces; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Number, sometimes with the decimal point at the front or between digits.
                    n = $urandom_range(1, 5);
                    point_at = $urandom_range(0, 2 * n);
                    for (i = 0; i < n; i++)
                    begin
                        if (i == point_at)
                            text_bytes.push_back(text_point);
                        text_bytes.push_back(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
                    end
                end
                2, 3:
                begin
                    // Function name, now and then cut short or extended.
                    fname = func_words[$urandom_range(0, NUM_FUNCS - 1)];
                    n = fname.len();
                    if ($urandom_range(0, 4) == 0)
                        n = n - 1;
                    for (i = 0; i < n; i++)
                        text_bytes.push_back(fname[i]);
                    if ($urandom_range(0, 5) == 0)
                        text_bytes.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
                end
                4:
                begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 1))
                            text_bytes.push_back(8'(CH_UPPER_A + $urandom_range(0, 25)));
                        else
                            text_bytes.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
                    end
                end
                5, 6, 7: text_bytes.push_back(separators[$urandom_range(0, 8)]);
                8: text_bytes.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    // Letter followed by a digit.
                    text_bytes.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
                    text_bytes.push_back(8'(CH_DIGIT_0 + $urandom_range(0, 9)));
                end
            endcase
            if ($urandom_range(0, 9) < 6)
                text_bytes.push_back(separators[$urandom_range(0, 7)]);
        end
    endtask

    task automatic cfg_write(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        text_point = value;
    endtask

    // Let every predicted token come out, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (tokens_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] point_settings [NUM_SETTINGS];
        int         phase;
        int         phase_start;

        point_settings = '{8'h00, 8'hFF, CH_PLUS, CH_SPACE, CH_NEWLINE, 8'h65,
                           8'h00, DECIMAL_POINT_RESET};
        point_settings[6] = 8'($urandom_range(0, 255));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed texts under the reset decimal point: every name, operator,
        // paren, space, newline, and both ways a text can end.
        sender_gaps = 1'b1;
        send_string("sin(9.)/cos");
        send_string("tan-cot*abs^");
        send_string("minus+ \n");

        // Random texts under each decimal point setting.
        for (phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            drain();
            cfg_write(point_settings[phase]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 6) == 0)
                begin
                    send_noise();
                end
                else
                begin
                    build_expression();
                    send_text_bytes();
                end
            end
        end
        drain();

        $display("Sent %0d bytes under the reset decimal point and %0d written ones,",
                 bytes_sent, NUM_SETTINGS);
        $display("covering every function name and split byte; %0d tokens compared.",
                 tokens_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Timed out with %0d tokens outstanding.", tokens_pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: expression_token_classifier.f
src/etc_pkg.sv
src/etc_out_queue.sv
src/expression_token_classifier.sv
tb/sv/etc_checker.sv
tb/sv/tb.sv
